/* rtl/becm_pkg.sv */
// Shared types and constants for the binned event count map.
// Used by becm_div and binned_event_count_map; depends on nothing else.
`default_nettype none

package becm_pkg;

  localparam int MAP_COLS_DEF = 1024;
  localparam int MAP_ROWS_DEF = 256;

  localparam int POS_W    = 16;
  localparam int COORD_W  = 15;
  localparam int BIN_W    = 7;
  localparam int WEIGHT_W = 16;
  localparam int SCALE_W  = 16;
  localparam int PHA_W    = 8;
  localparam int COLS_W   = 11;
  localparam int ROWS_W   = 9;
  localparam int ADDR_W   = 18;
  localparam int VAL_W    = 32;
  localparam int TOTAL_W  = 48;
  localparam int PROD_W   = WEIGHT_W + SCALE_W;
  localparam int CONTRIB_W = PROD_W - 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PHA_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHA_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 3'd7;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_INDEX,
    ST_FETCH,
    ST_MODIFY,
    ST_REPLY
  } becm_state_t;

endpackage

`default_nettype wire

/* rtl/binned_event_count_map.sv */
// Weighted 2-D event histogram held in one synchronous map memory.
// After reset the map is cleared one cell a cycle, during which no item is taken. A read
// command is taken, fetches its cell and replies; an accumulate command is taken, runs the
// 15-bit coordinate dividers, then the index, fetch and read-modify-write of one map cell,
// or goes from the index straight to the reply when the event is rejected. Depends on
// becm_pkg and becm_div.
`default_nettype none

module binned_event_count_map #(
  parameter int MAP_COLS = becm_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = becm_pkg::MAP_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [becm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [becm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [becm_pkg::POS_W-1:0]    pos_x,
  input  logic signed [becm_pkg::POS_W-1:0]    pos_y,
  input  logic [becm_pkg::WEIGHT_W-1:0]        event_weight,
  input  logic [becm_pkg::PHA_W-1:0]           pulse_height,
  input  logic [becm_pkg::ADDR_W-1:0]          read_addr,
  input  logic                                 batch_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 accepted,
  output logic [becm_pkg::ADDR_W-1:0]          cell_index,
  output logic signed [becm_pkg::VAL_W-1:0]    cell_value,
  output logic [becm_pkg::TOTAL_W-1:0]         batch_total,
  output logic                                 batch_done
);
  import becm_pkg::*;

  localparam int CELLS  = MAP_COLS * MAP_ROWS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NC_W   = $clog2(MAP_COLS + 1);
  localparam int NR_W   = $clog2(MAP_ROWS + 1);
  localparam int IDXP_W = COORD_W + NC_W;
  localparam logic [VAL_W+1:0] VAL_MAX = (VAL_W+2)'(34'sd2147483647);
  localparam logic [VAL_W+1:0] VAL_MIN = (VAL_W+2)'(-34'sd2147483648);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  becm_state_t state, state_next;

  logic [PHA_W-1:0]    pha_low, pha_high;
  logic                subtract_mode;
  logic [SCALE_W-1:0]  scale_factor;
  logic [BIN_W-1:0]    bin_x, bin_y;
  logic [COLS_W-1:0]   cols_used;
  logic [ROWS_W-1:0]   rows_used;

  logic [BIN_W-1:0]    bx, by;
  logic [NC_W-1:0]     nc;
  logic [NR_W-1:0]     nr;
  logic [NC_W+BIN_W-1:0] lim_x;
  logic [NR_W+BIN_W-1:0] lim_y;

  logic                is_read, pha_ok, bend_q, rd_in_range, keep;
  logic signed [POS_W-1:0] px_q, py_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [ADDR_W-1:0]   raddr_q;
  logic [PROD_W-1:0]   prod;
  logic [CONTRIB_W-1:0] contrib;
  logic [CELL_W-1:0]   cell_q, clr_addr;
  logic [IDXP_W-1:0]   cell_full;

  logic                div_start, qx_done, qy_done;
  logic [COORD_W-1:0]  qx, qy;

  logic signed [VAL_W-1:0] map_mem [CELLS];
  logic signed [VAL_W-1:0] mem_rdata;
  logic                mem_we, mem_re;
  logic [CELL_W-1:0]   mem_addr;
  logic signed [VAL_W-1:0] mem_wdata;

  logic                out_free, out_load;
  logic [VAL_W+1:0]    nv;
  logic signed [VAL_W-1:0] nv_sat;
  logic [TOTAL_W:0]    tot_sum;
  logic [TOTAL_W-1:0]  tot_sat;
  logic [TOTAL_W-1:0]  running_total_q;
  logic                in_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pha_low       <= '0;
      pha_high      <= PHA_W'(31);
      subtract_mode <= 1'b0;
      scale_factor  <= SCALE_W'(256);
      bin_x         <= BIN_W'(1);
      bin_y         <= BIN_W'(1);
      cols_used     <= COLS_W'(1024);
      rows_used     <= ROWS_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHA_LOW:   pha_low       <= cfg_data[PHA_W-1:0];
        REG_PHA_HIGH:  pha_high      <= cfg_data[PHA_W-1:0];
        REG_SUBTRACT:  subtract_mode <= cfg_data[0];
        REG_SCALE:     scale_factor  <= cfg_data[SCALE_W-1:0];
        REG_BIN_X:     bin_x         <= cfg_data[BIN_W-1:0];
        REG_BIN_Y:     bin_y         <= cfg_data[BIN_W-1:0];
        REG_COLS_USED: cols_used     <= cfg_data[COLS_W-1:0];
        REG_ROWS_USED: rows_used     <= cfg_data[ROWS_W-1:0];
      endcase
    end
  end

  always_comb begin
    bx = (bin_x == '0) ? BIN_W'(1) : bin_x;
    by = (bin_y == '0) ? BIN_W'(1) : bin_y;
    if (cols_used == '0) begin
      nc = NC_W'(1);
    end else if (32'(cols_used) > 32'(MAP_COLS)) begin
      nc = NC_W'(MAP_COLS);
    end else begin
      nc = NC_W'(cols_used);
    end
    if (rows_used == '0) begin
      nr = NR_W'(1);
    end else if (32'(rows_used) > 32'(MAP_ROWS)) begin
      nr = NR_W'(MAP_ROWS);
    end else begin
      nr = NR_W'(rows_used);
    end
  end

  always_ff @(posedge clk) begin
    lim_x <= (NC_W+BIN_W)'(nc) * (NC_W+BIN_W)'(bx);
    lim_y <= (NR_W+BIN_W)'(nr) * (NR_W+BIN_W)'(by);
  end

  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      is_read     <= (cmd == CMD_READ);
      px_q        <= pos_x;
      py_q        <= pos_y;
      weight_q    <= event_weight;
      pha_ok      <= (pulse_height >= pha_low) && (pulse_height <= pha_high);
      bend_q      <= batch_end;
      raddr_q     <= read_addr;
      rd_in_range <= (32'(read_addr) < 32'(CELLS));
    end
    if (state == ST_DIV) begin
      prod <= PROD_W'(weight_q) * PROD_W'(scale_factor);
    end
    if (state == ST_DIV && qx_done) begin
      keep <= pha_ok && !px_q[POS_W-1] && !py_q[POS_W-1] &&
              (32'(px_q[COORD_W-1:0]) < 32'(lim_x)) &&
              (32'(py_q[COORD_W-1:0]) < 32'(lim_y));
    end
    if (state == ST_INDEX) begin
      cell_q <= cell_full[CELL_W-1:0];
    end
  end

  assign div_start = in_xfer && (cmd == CMD_ACCUMULATE);

  becm_div #(.DIVIDEND_W(COORD_W), .DIVISOR_W(BIN_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pos_x[COORD_W-1:0]),
    .divisor  (bx),
    .quotient (qx),
    .done     (qx_done)
  );

  becm_div #(.DIVIDEND_W(COORD_W), .DIVISOR_W(BIN_W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pos_y[COORD_W-1:0]),
    .divisor  (by),
    .quotient (qy),
    .done     (qy_done)
  );

  assign cell_full = IDXP_W'(qy) * IDXP_W'(nc) + IDXP_W'(qx);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = cell_q;
    mem_wdata  = nv_sat;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
        if (clr_addr == CELL_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (cmd == CMD_READ) ? ST_FETCH : ST_DIV;
        end
      end
      ST_DIV: begin
        if (qx_done) begin
          state_next = ST_INDEX;
        end
      end
      ST_INDEX: begin
        state_next = keep ? ST_FETCH : ST_REPLY;
      end
      ST_FETCH: begin
        mem_addr   = is_read ? CELL_W'(raddr_q) : cell_q;
        mem_re     = is_read ? rd_in_range : 1'b1;
        state_next = is_read ? ST_REPLY : ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) begin
          mem_we     = 1'b1;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= map_mem[mem_addr];
    end
  end

  always_comb begin
    contrib = CONTRIB_W'(((PROD_W+1)'(prod) + (PROD_W+1)'(8)) >> 4);
    nv = subtract_mode ? ((VAL_W+2)'(mem_rdata) - (VAL_W+2)'(contrib))
                       : ((VAL_W+2)'(mem_rdata) + (VAL_W+2)'(contrib));
    if ($signed(nv) > $signed(VAL_MAX)) begin
      nv_sat = VAL_MAX[VAL_W-1:0];
    end else if ($signed(nv) < $signed(VAL_MIN)) begin
      nv_sat = VAL_MIN[VAL_W-1:0];
    end else begin
      nv_sat = nv[VAL_W-1:0];
    end
    tot_sum = (TOTAL_W+1)'(running_total_q) + (TOTAL_W+1)'(contrib);
    tot_sat = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      running_total_q <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load && !is_read) begin
        if (bend_q) begin
          running_total_q <= '0;
        end else if (state == ST_MODIFY) begin
          running_total_q <= tot_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (is_read) begin
        accepted    <= 1'b0;
        cell_index  <= raddr_q;
        cell_value  <= rd_in_range ? mem_rdata : '0;
        batch_total <= running_total_q;
        batch_done  <= 1'b0;
      end else if (state == ST_MODIFY) begin
        accepted    <= 1'b1;
        cell_index  <= ADDR_W'(cell_q);
        cell_value  <= nv_sat;
        batch_total <= tot_sat;
        batch_done  <= bend_q;
      end else begin
        accepted    <= 1'b0;
        cell_index  <= '0;
        cell_value  <= '0;
        batch_total <= running_total_q;
        batch_done  <= bend_q;
      end
    end
  end

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR) || (state == ST_MODIFY && out_load))
    else $error("map written outside the clearing pass or an update");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MODIFY || state == ST_REPLY))
    else $error("result raised without a finished item");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state != ST_IDLE)
    else $error("item taken but sequencer stayed idle");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    out_load && !is_read && bend_q |=> running_total_q == '0)
    else $error("batch total not cleared after the last event");

  a_div_pair: assert property (@(posedge clk) disable iff (rst)
    qx_done == qy_done)
    else $error("coordinate dividers out of step");

endmodule

`default_nettype wire

/* rtl/becm_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on becm_pkg for its default widths.
`default_nettype none

module becm_div #(
  parameter int DIVIDEND_W = becm_pkg::COORD_W,
  parameter int DIVISOR_W  = becm_pkg::BIN_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);
  import becm_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    shifted;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[DIVIDEND_W-1]};
    ge       = (shifted >= {1'b0, dsr});
    rem_next = ge ? DIVISOR_W'(shifted - {1'b0, dsr}) : shifted[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire
